// ===== src/utd_pkg.sv =====
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types and constants of the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

	localparam int CpWidth = 21;
	localparam int AccWidth = CpWidth;
	localparam int BufDepth = 2;

	localparam logic [CpWidth-1:0] ReplCp = 21'h00FFFD;

	localparam logic [1:0] PushNone = 2'd0;
	localparam logic [1:0] PushOne = 2'd1;
	localparam logic [1:0] PushTwo = 2'd2;

	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		logic is_replacement;
		logic last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

// ===== src/utd_if.sv =====
// ----------------------------------------------------------------------------
// utd_if
// Valid/ready channels: raw bytes in, decoded code points out.
// ----------------------------------------------------------------------------
interface utd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic end_of_string;

	modport source(output valid, output in_byte, output end_of_string, input ready);
	modport sink(input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utd_cp_if;
	logic valid;
	logic ready;
	logic [utd_pkg::CpWidth-1:0] code_point;
	logic is_replacement;
	logic last_of_run;

	modport source(output valid, output code_point, output is_replacement,
		output last_of_run, input ready);
	modport sink(input valid, input code_point, input is_replacement,
		input last_of_run, output ready);
endinterface

// ===== src/utd_decode.sv =====
// ----------------------------------------------------------------------------
// utd_decode
// Decoder state and the byte classifier that yields zero to two results.
// ----------------------------------------------------------------------------
module utd_decode (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] in_byte,
	input  logic end_of_string,
	input  logic advance,
	output utd_pkg::push_t push
);

	logic [utd_pkg::AccWidth-1:0] acc_q;
	logic [1:0] pend_q;
	logic [utd_pkg::AccWidth-1:0] acc_n;
	logic [1:0] pend_n;
	logic [1:0] cnt;
	utd_pkg::result_t r [2];

	always_comb begin
		acc_n = acc_q;
		pend_n = pend_q;
		cnt = utd_pkg::PushNone;
		r[0] = '0;
		r[1] = '0;
		case (in_byte) inside
			[8'h00:8'h7F]: begin
				if (pend_q != 2'd0) begin
					r[cnt[0]] = '{utd_pkg::ReplCp, 1'b1, 1'b0};
					cnt = cnt + 2'd1;
				end
				pend_n = 2'd0;
				r[cnt[0]] = '{{13'd0, in_byte}, 1'b0, 1'b0};
				cnt = cnt + 2'd1;
			end
			[8'h80:8'hBF]: begin
				if (pend_q != 2'd0) begin
					acc_n = {acc_q[utd_pkg::AccWidth-7:0], in_byte[5:0]};
					pend_n = pend_q - 2'd1;
					if (pend_n == 2'd0) begin
						r[cnt[0]] = '{acc_n, 1'b0, 1'b0};
						cnt = cnt + 2'd1;
					end
				end else begin
					r[cnt[0]] = '{utd_pkg::ReplCp, 1'b1, 1'b0};
					cnt = cnt + 2'd1;
				end
			end
			[8'hC0:8'hDF]: begin
				pend_n = 2'd1;
				acc_n = {16'd0, in_byte[4:0]};
			end
			[8'hE0:8'hEF]: begin
				pend_n = 2'd2;
				acc_n = {17'd0, in_byte[3:0]};
			end
			[8'hF0:8'hF7]: begin
				pend_n = 2'd3;
				acc_n = {18'd0, in_byte[2:0]};
			end
			default: begin
				r[cnt[0]] = '{utd_pkg::ReplCp, 1'b1, 1'b0};
				cnt = cnt + 2'd1;
				pend_n = 2'd0;
			end
		endcase
		if (end_of_string) begin
			if (pend_n != 2'd0) begin
				r[cnt[0]] = '{utd_pkg::ReplCp, 1'b1, 1'b0};
				cnt = cnt + 2'd1;
			end
			pend_n = 2'd0;
			acc_n = '0;
		end
		if (cnt == utd_pkg::PushOne) begin
			r[0].last_of_run = 1'b1;
		end else if (cnt == utd_pkg::PushTwo) begin
			r[1].last_of_run = 1'b1;
		end
		push.n = cnt;
		push.r0 = r[0];
		push.r1 = r[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pend_q <= 2'd0;
		end else if (advance) begin
			acc_q <= acc_n;
			pend_q <= pend_n;
		end
	end

endmodule

// ===== src/utd_result_buf.sv =====
// ----------------------------------------------------------------------------
// utd_result_buf
// Two-entry result queue; takes up to two results per cycle, sends one if ready.
// ----------------------------------------------------------------------------
module utd_result_buf (
	input  logic clk,
	input  logic arst_n,
	input  utd_pkg::push_t push,
	output logic [1:0] count,
	utd_cp_if.source cp_chan
);

	utd_pkg::result_t slot_q [utd_pkg::BufDepth];
	utd_pkg::result_t slot_n [utd_pkg::BufDepth];
	logic [1:0] count_q;
	logic [1:0] count_n;
	logic [1:0] rem_cnt;
	logic pop;

	assign pop = (count_q != 2'd0) && cp_chan.ready;

	always_comb begin
		rem_cnt = count_q - {1'b0, pop};
		slot_n[0] = pop ? slot_q[1] : slot_q[0];
		slot_n[1] = slot_q[1];
		if (push.n != utd_pkg::PushNone) begin
			if (rem_cnt == 2'd0) begin
				slot_n[0] = push.r0;
			end else begin
				slot_n[1] = push.r0;
			end
		end
		if (push.n == utd_pkg::PushTwo) begin
			slot_n[1] = push.r1;
		end
		count_n = rem_cnt + push.n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_n[0];
		slot_q[1] <= slot_n[1];
	end

	assign count = count_q;
	assign cp_chan.valid = count_q != 2'd0;
	assign cp_chan.code_point = slot_q[0].code_point;
	assign cp_chan.is_replacement = slot_q[0].is_replacement;
	assign cp_chan.last_of_run = slot_q[0].last_of_run;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result queue over capacity");

endmodule

// ===== src/utd_to_codepoint_top_placeholder.sv =====
// ----------------------------------------------------------------------------
// utd_input_reg
// Input byte register between the byte channel and the decoder.
// ----------------------------------------------------------------------------
module utd_input_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic consume,
	output logic valid,
	output logic [7:0] in_byte,
	output logic end_of_string,
	utd_byte_if.sink byte_chan
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eos_s1;
	logic load;

	assign byte_chan.ready = !valid_s1 || consume;
	assign load = byte_chan.valid && byte_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= byte_chan.in_byte;
			eos_s1 <= byte_chan.end_of_string;
		end
	end

	assign valid = valid_s1;
	assign in_byte = byte_s1;
	assign end_of_string = eos_s1;

endmodule

// ===== src/utf8_to_codepoint_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_unit
// UTF-8 byte stream to code point decoder with error replacement.
// ----------------------------------------------------------------------------
// channel    dir  payload                                     handshake
// byte_chan  in   in_byte[7:0], end_of_string                 valid/ready
// cp_chan    out  code_point[20:0], is_replacement, last_of_run valid/ready
//
// One byte per cycle unless the input stalls; a transfer passes through the
// input register and the result queue to the output. A byte that yields two
// results holds the input register while the two-entry result queue drains.
// Reset clears the decoder state, the input valid flag and the queue count.
// An output stall holds the queue; the input stalls while the queue, after
// this cycle's output transfer, has no room for the byte's results.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_unit (
	input  logic clk,
	input  logic arst_n,
	utd_byte_if.sink byte_chan,
	utd_cp_if.source cp_chan
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eos_s1;
	logic consume;
	logic out_xfer;
	logic [1:0] count;
	utd_pkg::push_t dec;
	utd_pkg::push_t push;

	assign out_xfer = cp_chan.valid && cp_chan.ready;
	assign consume = valid_s1 &&
		({1'b0, count} - {2'b0, out_xfer} + {1'b0, dec.n} <= 3'd2);

	always_comb begin
		push = dec;
		if (!consume) begin
			push.n = utd_pkg::PushNone;
		end
	end

	utd_input_reg u_input (
		.clk           (clk),
		.arst_n        (arst_n),
		.consume       (consume),
		.valid         (valid_s1),
		.in_byte       (byte_s1),
		.end_of_string (eos_s1),
		.byte_chan     (byte_chan)
	);

	utd_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_byte       (byte_s1),
		.end_of_string (eos_s1),
		.advance       (consume),
		.push          (dec)
	);

	utd_result_buf u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.count   (count),
		.cp_chan (cp_chan)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		consume |-> ({1'b0, count} - {2'b0, out_xfer} + {1'b0, dec.n} <= 3'd2))
		else $error("result queue overflow on transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(dec.n == utd_pkg::PushTwo) |-> (!dec.r0.last_of_run && dec.r1.last_of_run))
		else $error("run end marked on wrong result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !consume) |=> (valid_s1 && $stable(byte_s1) && $stable(eos_s1)))
		else $error("held input byte lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		(dec.n != utd_pkg::PushNone && !dec.r0.is_replacement) |->
		(dec.r0.code_point != utd_pkg::ReplCp || byte_s1 >= 8'h80))
		else $error("replacement emitted without flag");

endmodule
